FILE: src/ehc_pkg.sv
// Package with shared types, constants and codes of the Ethernet header classifier.
package ehc_pkg;

	localparam int FRAME_MAX_BYTES = 1514;
	localparam int POS_W           = 11;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DATA_W      = 400;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(FRAME_MAX_BYTES);

	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_IPV6 = 16'h86DD;
	localparam logic [15:0] ET_ARP  = 16'h0806;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

	localparam logic [2:0] ST_OWN_DROP   = 3'd0;
	localparam logic [2:0] ST_BCAST_DROP = 3'd1;
	localparam logic [2:0] ST_UNKNOWN_ET = 3'd2;
	localparam logic [2:0] ST_ARP        = 3'd3;
	localparam logic [2:0] ST_ICMP       = 3'd4;
	localparam logic [2:0] ST_TCP        = 3'd5;
	localparam logic [2:0] ST_UDP        = 3'd6;
	localparam logic [2:0] ST_UNKNOWN_IP = 3'd7;

	localparam logic [1:0] VER_NONE = 2'd0;
	localparam logic [1:0] VER_IPV4 = 2'd1;
	localparam logic [1:0] VER_IPV6 = 2'd2;

	localparam logic [1:0] REG_OWN_MAC    = 2'd0;
	localparam logic [1:0] REG_KEEP_OWN   = 2'd1;
	localparam logic [1:0] REG_BCAST_ONLY = 2'd2;

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [15:0] eth_type;
		logic [7:0]  protocol;
		logic [63:0] source_ip_high;
		logic [63:0] source_ip_low;
		logic [63:0] dest_ip_high;
		logic [63:0] dest_ip_low;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] arp_opcode;
		logic [47:0] arp_sender_mac;
		logic [47:0] arp_target_mac;
	} hdr_rec_t;

	typedef struct packed {
		logic [47:0] own_mac;
		logic        keep_own_frames;
		logic        broadcast_only;
	} cfg_t;

endpackage

FILE: src/ehc_capture.sv
// Front part: takes frame bytes, captures header fields and hands one record per frame.
module ehc_capture (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             q_full,
	output logic             in_ready,
	output logic             rec_push,
	output ehc_pkg::hdr_rec_t rec_data
);
	import ehc_pkg::*;

	logic [POS_W-1:0] pos_q;
	hdr_rec_t         cap_q;
	hdr_rec_t         cap_nxt;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign rec_push = accept && in_last;
	assign rec_data = cap_nxt;

	always_comb begin
		cap_nxt = cap_q;
		if (pos_q < POS_W'(6)) begin
			cap_nxt.dest_mac = {cap_q.dest_mac[39:0], in_byte};
		end else if (pos_q < POS_W'(12)) begin
			cap_nxt.source_mac = {cap_q.source_mac[39:0], in_byte};
		end else if (pos_q < POS_W'(14)) begin
			cap_nxt.eth_type = {cap_q.eth_type[7:0], in_byte};
		end else if (cap_q.eth_type == ET_IPV4) begin
			if (pos_q == POS_W'(23)) begin
				cap_nxt.protocol = in_byte;
			end else if (pos_q >= POS_W'(26) && pos_q < POS_W'(30)) begin
				cap_nxt.source_ip_low = {cap_q.source_ip_low[55:0], in_byte};
			end else if (pos_q >= POS_W'(30) && pos_q < POS_W'(34)) begin
				cap_nxt.dest_ip_low = {cap_q.dest_ip_low[55:0], in_byte};
			end else if (pos_q >= POS_W'(34) && pos_q < POS_W'(36)) begin
				cap_nxt.source_port = {cap_q.source_port[7:0], in_byte};
			end else if (pos_q >= POS_W'(36) && pos_q < POS_W'(38)) begin
				cap_nxt.dest_port = {cap_q.dest_port[7:0], in_byte};
			end
		end else if (cap_q.eth_type == ET_IPV6) begin
			if (pos_q == POS_W'(20)) begin
				cap_nxt.protocol = in_byte;
			end else if (pos_q >= POS_W'(22) && pos_q < POS_W'(30)) begin
				cap_nxt.source_ip_high = {cap_q.source_ip_high[55:0], in_byte};
			end else if (pos_q >= POS_W'(30) && pos_q < POS_W'(38)) begin
				cap_nxt.source_ip_low = {cap_q.source_ip_low[55:0], in_byte};
			end else if (pos_q >= POS_W'(38) && pos_q < POS_W'(46)) begin
				cap_nxt.dest_ip_high = {cap_q.dest_ip_high[55:0], in_byte};
			end else if (pos_q >= POS_W'(46) && pos_q < POS_W'(54)) begin
				cap_nxt.dest_ip_low = {cap_q.dest_ip_low[55:0], in_byte};
			end else if (pos_q >= POS_W'(54) && pos_q < POS_W'(56)) begin
				cap_nxt.source_port = {cap_q.source_port[7:0], in_byte};
			end else if (pos_q >= POS_W'(56) && pos_q < POS_W'(58)) begin
				cap_nxt.dest_port = {cap_q.dest_port[7:0], in_byte};
			end
		end else if (cap_q.eth_type == ET_ARP) begin
			if (pos_q >= POS_W'(20) && pos_q < POS_W'(22)) begin
				cap_nxt.arp_opcode = {cap_q.arp_opcode[7:0], in_byte};
			end else if (pos_q >= POS_W'(22) && pos_q < POS_W'(28)) begin
				cap_nxt.arp_sender_mac = {cap_q.arp_sender_mac[39:0], in_byte};
			end else if (pos_q >= POS_W'(28) && pos_q < POS_W'(32)) begin
				cap_nxt.source_ip_low = {cap_q.source_ip_low[55:0], in_byte};
			end else if (pos_q >= POS_W'(32) && pos_q < POS_W'(38)) begin
				cap_nxt.arp_target_mac = {cap_q.arp_target_mac[39:0], in_byte};
			end else if (pos_q >= POS_W'(38) && pos_q < POS_W'(42)) begin
				cap_nxt.dest_ip_low = {cap_q.dest_ip_low[55:0], in_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cap_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q <= '0;
				cap_q <= '0;
			end else begin
				cap_q <= cap_nxt;
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

FILE: src/ehc_queue.sv
// Short register queue of captured header records between front and back parts.
module ehc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ehc_pkg::hdr_rec_t push_data,
	input  logic              pop,
	output ehc_pkg::hdr_rec_t head_data,
	output logic              full,
	output logic              empty,
	output logic [ehc_pkg::QCNT_W-1:0] count
);
	import ehc_pkg::*;

	hdr_rec_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty     = count_q == '0;
	assign count     = count_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/ehc_classify.sv
// Back part: classifies the queued header record and holds the result in an output register.
module ehc_classify (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ehc_pkg::cfg_t              cfg,
	input  ehc_pkg::hdr_rec_t          rec,
	input  logic                       rec_valid,
	output logic                       rec_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 out_status,
	output logic [ehc_pkg::OUT_DATA_W-1:0] out_data
);
	import ehc_pkg::*;

	logic [2:0]  status;
	logic [1:0]  ver;
	logic [63:0] sih;
	logic [63:0] sil;
	logic [63:0] dih;
	logic [63:0] dil;
	logic [7:0]  proto;
	logic [15:0] sp;
	logic [15:0] dp;
	logic [2:0]  flags;
	logic        valid_q;
	logic [2:0]  status_q;
	logic [OUT_DATA_W-1:0] data_q;

	always_comb begin
		status = ST_UNKNOWN_ET;
		ver    = VER_NONE;
		sih    = '0;
		sil    = '0;
		dih    = '0;
		dil    = '0;
		proto  = '0;
		sp     = '0;
		dp     = '0;
		flags  = '0;
		priority if (!cfg.keep_own_frames && rec.source_mac == cfg.own_mac) begin
			status = ST_OWN_DROP;
		end else if (cfg.broadcast_only && rec.dest_mac != BCAST_MAC) begin
			status = ST_BCAST_DROP;
		end else if (rec.eth_type == ET_ARP) begin
			status   = ST_ARP;
			ver      = VER_IPV4;
			sil      = {32'd0, rec.source_ip_low[31:0]};
			dil      = {32'd0, rec.dest_ip_low[31:0]};
			flags[0] = rec.arp_sender_mac != rec.source_mac;
			if (rec.arp_opcode == ARP_OP_REPLY) begin
				flags[1] = rec.arp_target_mac != rec.dest_mac;
			end else if (rec.arp_opcode != ARP_OP_REQUEST) begin
				flags[2] = 1'b1;
			end
		end else if (rec.eth_type == ET_IPV4 || rec.eth_type == ET_IPV6) begin
			if (rec.eth_type == ET_IPV4) begin
				ver = VER_IPV4;
				sil = {32'd0, rec.source_ip_low[31:0]};
				dil = {32'd0, rec.dest_ip_low[31:0]};
			end else begin
				ver = VER_IPV6;
				sih = rec.source_ip_high;
				sil = rec.source_ip_low;
				dih = rec.dest_ip_high;
				dil = rec.dest_ip_low;
			end
			proto = rec.protocol;
			priority if (proto == PROTO_ICMP) begin
				status = ST_ICMP;
			end else if (proto == PROTO_TCP) begin
				status = ST_TCP;
			end else if (proto == PROTO_UDP) begin
				status = ST_UDP;
			end else begin
				status = ST_UNKNOWN_IP;
			end
			if (status == ST_TCP || status == ST_UDP) begin
				sp = rec.source_port;
				dp = rec.dest_port;
			end
		end else begin
			status = ST_UNKNOWN_ET;
		end
	end

	assign rec_pop    = rec_valid && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign out_status = status_q;
	assign out_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			status_q <= status;
			data_q   <= {3'd0, flags, dp, sp, proto, dil, dih, sil, sih,
				rec.dest_mac, rec.source_mac, ver};
		end
	end

endmodule

FILE: src/ethernet_header_classifier_top.sv
// Top level of the Ethernet header classifier: configuration registers, front, queue and back.
//
// Channel  Direction  Handshake            Payload
// s_axis   in         s_tvalid / s_tready  s_tdata data_byte, s_tlast frame_end
// m_axis   out        m_tvalid / m_tready  m_tdata header fields, m_tuser status
// cfg      in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One byte is taken in every cycle while the record queue has a free entry.
// After the last byte of its frame, a result is held first in the queue and then in the
// output register; the four-entry queue absorbs stalls.
// The reset clears positions, captured fields, queue pointers and output valid.
// Configuration writes are taken in every cycle.
module ethernet_header_classifier_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] data_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [1:0] ip_version, [49:2] source_mac, [97:50] dest_mac, [161:98] source_ip_high,
	// [225:162] source_ip_low, [289:226] dest_ip_high, [353:290] dest_ip_low,
	// [361:354] protocol_number, [377:362] source_port, [393:378] dest_port,
	// [396:394] arp_flags, [399:397] zero
	output logic [ehc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [2:0]   m_tuser,  // [2:0] status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [47:0]  cfg_data
);
	import ehc_pkg::*;

	cfg_t              cfg_q;
	hdr_rec_t          push_rec;
	hdr_rec_t          head_rec;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_mac         <= '0;
			cfg_q.keep_own_frames <= 1'b1;
			cfg_q.broadcast_only  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OWN_MAC:    cfg_q.own_mac         <= cfg_data;
				REG_KEEP_OWN:   cfg_q.keep_own_frames <= cfg_data[0];
				REG_BCAST_ONLY: cfg_q.broadcast_only  <= cfg_data[0];
				default:        cfg_q                 <= cfg_q;
			endcase
		end
	end

	ehc_capture u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.rec_push (q_push),
		.rec_data (push_rec)
	);

	ehc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_rec),
		.pop       (q_pop),
		.head_data (head_rec),
		.full      (q_full),
		.empty     (q_empty),
		.count     (q_count)
	);

	ehc_classify u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.rec        (head_rec),
		.rec_valid  (!q_empty),
		.rec_pop    (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_data   (m_tdata)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("record queue count exceeds its depth");

	a_frame_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !q_empty)
		else $error("frame end did not leave a record in the queue");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_OWN_DROP || m_tuser == ST_BCAST_DROP))
		|-> (m_tdata[1:0] == VER_NONE && m_tdata[396:98] == '0))
		else $error("dropped frame result carries header fields");

	a_pop_only_stored: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back part took a record from an empty queue");

endmodule
